### hw/rtl/rbd_pkg.sv
`default_nettype none

package rbd_pkg;

   // Frame size limits (defaults for the top level parameters)
   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_HEIGHT_DEF = 4096;

   // Configuration port
   localparam int CSR_W     = 13;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [CSR_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
   localparam logic [CSR_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

   // Pixel and pair sum formats
   localparam int PIX_W = 8;
   localparam int SUM_W = PIX_W + 1;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
   } pair_sum_type;

   localparam int PAIR_W = $bits(pair_sum_type);

   // Horizontal pair sum plus the matching line store entry, divided by four
   function automatic logic [PIX_W-1:0] quad_avg(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
      logic [SUM_W:0] total;
      total    = {1'b0, a} + {1'b0, b};
      quad_avg = total[SUM_W:2];
   endfunction

endpackage

`default_nettype wire

### hw/rtl/rgb_box_downscale_2x.sv
// Channel | Direction | Signals                                   | Handshake
// req     | in        | req_red, req_green, req_blue              | req_valid / req_ready
// rsp     | out       | rsp_avg_red/green/blue, rsp_last_of_frame | rsp_valid / rsp_ready
// csr     | in        | csr_index, csr_wr_data                    | csr_wr_en (no wait)
//
// One pixel per cycle while rsp is not stalled; a reduced pixel leaves after the
// transaction of its last input pixel (line store read, then output register).
// The line store has one write and one read port; writes happen on even rows,
// reads on odd rows, so the two never collide on the same entry.
// Synchronous active high reset clears positions, the held pixel and the pipe.
// A stalled rsp holds the pipe; req_ready drops only while a result waits.

`default_nettype none

module rgb_box_downscale_2x #(
   parameter int MAX_WIDTH  = rbd_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = rbd_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // input pixels
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [rbd_pkg::PIX_W-1:0]     req_red,
   input  wire logic [rbd_pkg::PIX_W-1:0]     req_green,
   input  wire logic [rbd_pkg::PIX_W-1:0]     req_blue,
   // reduced pixels
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [rbd_pkg::PIX_W-1:0]     rsp_avg_red,
   output logic      [rbd_pkg::PIX_W-1:0]     rsp_avg_green,
   output logic      [rbd_pkg::PIX_W-1:0]     rsp_avg_blue,
   output logic                               rsp_last_of_frame,
   // configuration
   input  wire logic                          csr_wr_en,
   input  wire logic [rbd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [rbd_pkg::CSR_W-1:0]     csr_wr_data
);

   import rbd_pkg::*;

   localparam int COL_W      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W      = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WD_W       = $clog2(MAX_WIDTH + 1);
   localparam int HT_W       = $clog2(MAX_HEIGHT + 1);
   localparam int WCMP_W     = (CSR_W > WD_W) ? CSR_W : WD_W;
   localparam int HCMP_W     = (CSR_W > HT_W) ? CSR_W : HT_W;
   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

   // Configuration registers
   logic [CSR_W-1:0] width_ff, width_in;
   logic [CSR_W-1:0] height_ff, height_in;

   // Position and horizontal pair state
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   pixel_type        held_ff, held_in;

   // Stage between line store read and output register
   logic             s1_valid_ff, s1_valid_in;
   pair_sum_type     s1_pair_ff, s1_pair_in;
   logic             s1_last_ff, s1_last_in;

   // Output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic             rsp_last_ff;

   logic [WD_W-1:0]   w_dim, used_w;
   logic [HT_W-1:0]   h_dim, used_h;
   logic [WCMP_W-1:0] width_ext;
   logic [HCMP_W-1:0] height_ext;
   logic              accept, out_take, in_region, produce;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] line_addr;
   pixel_type         cur_pix;
   pair_sum_type      pair_now, line_q;
   logic [PAIR_W-1:0] line_q_bits;

   // Configuration write decode
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wr_data;
            CSR_IMAGE_HEIGHT: height_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   // Clamp frame size to 1..MAX
   always_comb begin
      width_ext  = WCMP_W'(width_ff);
      height_ext = HCMP_W'(height_ff);
      if (width_ext == '0) begin
         w_dim = WD_W'(1);
      end else if (width_ext > WCMP_W'(MAX_WIDTH)) begin
         w_dim = WD_W'(MAX_WIDTH);
      end else begin
         w_dim = WD_W'(width_ext);
      end
      if (height_ext == '0) begin
         h_dim = HT_W'(1);
      end else if (height_ext > HCMP_W'(MAX_HEIGHT)) begin
         h_dim = HT_W'(MAX_HEIGHT);
      end else begin
         h_dim = HT_W'(height_ext);
      end
      used_w = {w_dim[WD_W-1:1], 1'b0};
      used_h = {h_dim[HT_W-1:1], 1'b0};
   end

   // Handshake
   assign out_take  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || out_take;
   assign accept    = req_valid && req_ready;

   assign cur_pix.red   = req_red;
   assign cur_pix.green = req_green;
   assign cur_pix.blue  = req_blue;

   // Horizontal pair sum of held left pixel and current pixel
   assign pair_now.red   = {1'b0, held_ff.red}   + {1'b0, cur_pix.red};
   assign pair_now.green = {1'b0, held_ff.green} + {1'b0, cur_pix.green};
   assign pair_now.blue  = {1'b0, held_ff.blue}  + {1'b0, cur_pix.blue};

   assign in_region = (WD_W'(col_ff) < used_w) && (HT_W'(row_ff) < used_h);
   assign produce   = accept && in_region && col_ff[0] && row_ff[0];
   assign wr_en     = accept && in_region && col_ff[0] && !row_ff[0];
   assign rd_en     = produce;
   assign line_addr = ADDR_W'(col_ff >> 1);

   // Position, held pixel and pipeline next state
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      held_in     = held_ff;
      s1_valid_in = s1_valid_ff;
      s1_pair_in  = s1_pair_ff;
      s1_last_in  = s1_last_ff;
      if (accept) begin
         if (in_region && !col_ff[0]) begin
            held_in = cur_pix;
         end
         if (WD_W'(col_ff) >= w_dim - WD_W'(1)) begin
            col_in = '0;
            if (HT_W'(row_ff) >= h_dim - HT_W'(1)) begin
               row_in = '0;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
      // stage 1 moves on when the output register can take it
      if (out_take) begin
         s1_valid_in = 1'b0;
      end
      if (produce) begin
         s1_valid_in = 1'b1;
         s1_pair_in  = pair_now;
         s1_last_in  = (WD_W'(col_ff) == used_w - WD_W'(1)) &&
                       (HT_W'(row_ff) == used_h - HT_W'(1));
      end
   end

   // Line store of even-row pair sums
   rbd_line_mem #(
      .DEPTH  (LINE_DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (PAIR_W)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (line_addr),
      .wr_data (pair_now),
      .rd_en   (rd_en),
      .rd_addr (line_addr),
      .rd_data (line_q_bits)
   );

   assign line_q = pair_sum_type'(line_q_bits);

   // Output register load
   assign rsp_valid_in = out_take ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (out_take && s1_valid_ff) begin
         rsp_red_ff   <= quad_avg(line_q.red, s1_pair_ff.red);
         rsp_green_ff <= quad_avg(line_q.green, s1_pair_ff.green);
         rsp_blue_ff  <= quad_avg(line_q.blue, s1_pair_ff.blue);
         rsp_last_ff  <= s1_last_ff;
      end
   end

   // Stage 1 payload
   always_ff @(posedge clock) begin
      s1_pair_ff <= s1_pair_in;
      s1_last_ff <= s1_last_in;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= IMAGE_WIDTH_RST;
         height_ff    <= IMAGE_HEIGHT_RST;
         col_ff       <= '0;
         row_ff       <= '0;
         held_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         held_ff      <= held_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_avg_red       = rsp_red_ff;
   assign rsp_avg_green     = rsp_green_ff;
   assign rsp_avg_blue      = rsp_blue_ff;
   assign rsp_last_of_frame = rsp_last_ff;

   // Checks
   a_ready_only_on_wait: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && rsp_valid_ff))
      else $error("req_ready low without a waiting result");

   a_line_port_excl: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("line store read and write in the same cycle");

   a_s1_to_out: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_take) |=> rsp_valid_ff)
      else $error("stage 1 result lost on its way to the output");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      accept |=> (WD_W'(col_ff) <= WD_W'(MAX_WIDTH - 1)))
      else $error("column position beyond maximum width");

endmodule

`default_nettype wire

### hw/rtl/rbd_line_mem.sv
`default_nettype none

module rbd_line_mem #(
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = 11,
   parameter int DATA_W = 27
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds its data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire
